// ===== hdl/b64d_pkg.sv =====
// Shared types, codes and the alphabet lookup for the strict base64 decoder.
`default_nettype none
package b64d_pkg;

  // Class of one input character after the alphabet lookup.
  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_PAD  = 2'd1;
  localparam logic [1:0] KIND_BAD  = 2'd2;

  localparam logic [7:0] CHAR_PAD = 8'h3D;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] group;
    logic       final_char;
  } item_t;

  // Maps a character to its 6-bit group; the kind says whether it is one.
  function automatic item_t classify(input logic [7:0] c, input logic fin);
    item_t it;
    it.final_char = fin;
    it.kind       = KIND_DATA;
    it.group      = 6'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      it.group = 6'(c - 8'h41);
    end else if (c inside {[8'h61:8'h7A]}) begin
      it.group = 6'(c - 8'h61 + 8'd26);
    end else if (c inside {[8'h30:8'h39]}) begin
      it.group = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      it.group = 6'd62;
    end else if (c == 8'h2F) begin
      it.group = 6'd63;
    end else if (c == CHAR_PAD) begin
      it.kind = KIND_PAD;
    end else begin
      it.kind = KIND_BAD;
    end
    return it;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/b64d_char_if.sv =====
// Handshake channel that carries one base64 text character per word.
`default_nettype none
interface b64d_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       final_char;

  modport source (output valid, output text_char, output final_char, input ready);
  modport sink (input valid, input text_char, input final_char, output ready);
endinterface
`default_nettype wire

// ===== hdl/b64d_byte_if.sv =====
// Handshake channel that carries one decoded result word.
`default_nettype none
interface b64d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       end_of_text;
  logic       malformed;

  modport source (output valid, output data_byte, output byte_valid,
                  output end_of_text, output malformed, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input end_of_text, input malformed, output ready);
endinterface
`default_nettype wire

// ===== hdl/b64d_front.sv =====
// Front end: accepts characters and classifies them through the alphabet.
`default_nettype none
module b64d_front (
  b64d_char_if.sink      chars,
  input  wire logic      full,
  output b64d_pkg::item_t push_item,
  output logic           push
);
  import b64d_pkg::*;

  assign chars.ready = !full;
  assign push        = chars.valid && !full;
  assign push_item   = classify(chars.text_char, chars.final_char);

endmodule
`default_nettype wire

// ===== hdl/b64d_fifo.sv =====
// Two-entry queue of classified characters between the front and back ends.
`default_nettype none
module b64d_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire b64d_pkg::item_t  push_item,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output b64d_pkg::item_t       head_item
);
  import b64d_pkg::*;

  item_t      entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/b64d_back.sv =====
// Back end: gathers 6-bit groups into bytes, checks padding and drives results.
`default_nettype none
module b64d_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire b64d_pkg::item_t head_item,
  output logic                 pop,
  b64d_byte_if.source          decoded
);
  import b64d_pkg::*;

  // The leftover count is kept in units of two bits: 0, 2, 4 or 6 bits.
  logic [5:0] leftover_bits;
  logic [1:0] leftover_pairs;
  logic [1:0] char_phase;
  logic [1:0] pad_seen;
  logic       error_seen;

  logic [5:0] leftover_bits_next;
  logic [1:0] leftover_pairs_next;
  logic [1:0] char_phase_next;
  logic [1:0] pad_seen_next;
  logic       error_seen_next;
  logic       have_byte;
  logic [7:0] byte_val;
  logic       bad;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end;
  logic       out_malformed;

  assign pop = head_valid && (!out_valid || decoded.ready);

  always_comb begin
    leftover_bits_next  = leftover_bits;
    leftover_pairs_next = leftover_pairs;
    char_phase_next     = char_phase + 2'd1;
    pad_seen_next       = pad_seen;
    error_seen_next     = error_seen;
    have_byte           = 1'b0;
    byte_val            = 8'd0;
    if (!error_seen) begin
      if (head_item.kind == KIND_PAD) begin
        if (pad_seen == 2'd2) begin
          error_seen_next = 1'b1;
        end else begin
          pad_seen_next = pad_seen + 2'd1;
        end
      end else if (pad_seen != 2'd0 || head_item.kind == KIND_BAD) begin
        error_seen_next = 1'b1;
      end else begin
        case (leftover_pairs)
          2'd0: begin
            leftover_bits_next  = head_item.group;
            leftover_pairs_next = 2'd3;
          end
          2'd1: begin
            have_byte           = 1'b1;
            byte_val            = {leftover_bits[1:0], head_item.group};
            leftover_bits_next  = 6'd0;
            leftover_pairs_next = 2'd0;
          end
          2'd2: begin
            have_byte           = 1'b1;
            byte_val            = {leftover_bits[3:0], head_item.group[5:2]};
            leftover_bits_next  = {4'd0, head_item.group[1:0]};
            leftover_pairs_next = 2'd1;
          end
          default: begin
            have_byte           = 1'b1;
            byte_val            = {leftover_bits, head_item.group[5:4]};
            leftover_bits_next  = {2'd0, head_item.group[3:0]};
            leftover_pairs_next = 2'd2;
          end
        endcase
      end
    end
    // Whole-text checks on the state as it stands after the final character.
    bad = error_seen_next
       || (char_phase_next == 2'd1)
       || (pad_seen_next != 2'd0 && char_phase_next != 2'd0)
       || (leftover_pairs_next != 2'd0 && leftover_bits_next != 6'd0)
       || (pad_seen_next == 2'd1 && leftover_pairs_next != 2'd1)
       || (pad_seen_next == 2'd2 && leftover_pairs_next != 2'd2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      leftover_bits  <= 6'd0;
      leftover_pairs <= 2'd0;
      char_phase     <= 2'd0;
      pad_seen       <= 2'd0;
      error_seen     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop) begin
        if (head_item.final_char) begin
          leftover_bits  <= 6'd0;
          leftover_pairs <= 2'd0;
          char_phase     <= 2'd0;
          pad_seen       <= 2'd0;
          error_seen     <= 1'b0;
        end else begin
          leftover_bits  <= leftover_bits_next;
          leftover_pairs <= leftover_pairs_next;
          char_phase     <= char_phase_next;
          pad_seen       <= pad_seen_next;
          error_seen     <= error_seen_next;
        end
        out_valid <= have_byte || head_item.final_char;
      end else if (decoded.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_byte       <= byte_val;
      out_byte_valid <= have_byte;
      out_end        <= head_item.final_char;
      out_malformed  <= head_item.final_char && bad;
    end
  end

  assign decoded.valid       = out_valid;
  assign decoded.data_byte   = out_byte;
  assign decoded.byte_valid  = out_byte_valid;
  assign decoded.end_of_text = out_end;
  assign decoded.malformed   = out_malformed;

endmodule
`default_nettype wire

// ===== hdl/base64_strict_decoder_top.sv =====
// Top level of the strict base64 decoder: front end, queue and back end.
// The chars channel takes one text character per word, with final_char set
// on the last character of a text. The decoded channel returns at most one
// word per character: a word appears when a byte completes (byte_valid) or
// when the character was final (end_of_text, with malformed telling whether
// the whole text broke the strict base64 rules). Characters that complete
// no byte and are not final produce no word.
// A character's word is registered first in the queue and then in the output
// register before it is offered. One character is accepted every cycle
// while the receiver keeps up; the alphabet lookup runs in the front end as
// a character enters the queue, and the shift and checks run combinationally
// in the back end ahead of the output register.
// A two-entry queue sits between the front end and the back end, and the
// back end holds its result in an output register. When the receiver stalls,
// the output register holds its word and the queue fills; chars.ready falls
// once both queue entries are taken.
// Synchronous reset empties the queue and the output register and clears the
// decoding state; it also clears after every final character.
`default_nettype none
module base64_strict_decoder_top (
  input  wire logic    clk,
  input  wire logic    rst,
  b64d_char_if.sink    chars,
  b64d_byte_if.source  decoded
);
  import b64d_pkg::*;

  item_t push_item;
  item_t head_item;
  logic  push;
  logic  full;
  logic  pop;
  logic  head_valid;

  b64d_front u_front (
    .chars     (chars),
    .full      (full),
    .push_item (push_item),
    .push      (push)
  );

  b64d_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  b64d_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .decoded    (decoded)
  );

  // A word is only offered for a completed byte or the end of a text.
  a_word_has_reason: assert property (@(posedge clk) disable iff (rst)
    decoded.valid |-> (decoded.byte_valid || decoded.end_of_text))
    else $error("result word with neither a byte nor end of text");

  // The malformed flag is only meaningful on the end-of-text word.
  a_malformed_at_end: assert property (@(posedge clk) disable iff (rst)
    (decoded.valid && decoded.malformed) |-> decoded.end_of_text)
    else $error("malformed flag outside the end-of-text word");

  // Taking a queue entry while the output word is stalled would lose it.
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (decoded.valid && !decoded.ready) |-> !pop)
    else $error("queue popped while the output word is stalled");

  // Nothing is offered right after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !decoded.valid)
    else $error("result offered right after reset");

endmodule
`default_nettype wire
